// ----- hdl/dcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Directed cycle detector package
// Shared sizes, types and the queue entry format for the detector.
// ----------------------------------------------------------------------------
package dcd_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int EDGE_W    = $clog2(MAX_EDGES);
    localparam int CNT_W     = EDGE_W + 1;
    localparam int SP_W      = NODE_W + 1;
    localparam int FIELD_W   = 11;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    // One classified request passed from the front to the back.
    typedef struct packed {
        logic              store;   // edge is in range, store it
        logic              drop;    // edge is out of range
        logic              last;    // final edge, run the walk
        logic [NODE_W-1:0] from_idx;
        logic [NODE_W-1:0] to_idx;
        logic [FIELD_W-1:0] nodes;  // effective node count at this edge
    } dcd_req_t;

endpackage

// ----- hdl/dcd_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module dcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/dcd_front.sv -----
// ----------------------------------------------------------------------------
// Detector front end
// Accepts edges, checks their range and queues classified requests.
// ----------------------------------------------------------------------------
module dcd_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [10:0]        node_count,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [21:0]        s_tdata,
    input  logic               s_tlast,
    output dcd_pkg::dcd_req_t  q_data,
    output logic               q_valid,
    input  logic               q_pop
);
    import dcd_pkg::*;

    dcd_req_t          q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic [FIELD_W-1:0] eff_n, from_n, to_n;
    logic              push;
    dcd_req_t          req;

    assign from_n = s_tdata[10:0];
    assign to_n   = s_tdata[21:11];
    assign eff_n  = (node_count > FIELD_W'(MAX_NODES)) ? FIELD_W'(MAX_NODES) : node_count;

    // Classify the edge against the node count in force now.
    always_comb begin
        req.drop     = (from_n == '0) || (to_n == '0) || (from_n > eff_n) || (to_n > eff_n);
        req.store    = !req.drop;
        req.last     = s_tlast;
        req.from_idx = NODE_W'(from_n - 11'd1);
        req.to_idx   = NODE_W'(to_n - 11'd1);
        req.nodes    = eff_n;
    end

    assign s_tready = (cnt_reg < (QPTR_W+1)'(QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = q_mem_reg[rp_reg];

    // Queue pointers.
    always_comb begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = q_pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wp_reg] <= req;
        end
    end

endmodule

// ----- hdl/dcd_back.sv -----
// ----------------------------------------------------------------------------
// Detector back end
// Stores edges in adjacency lists, runs the depth-first walk and clears.
// ----------------------------------------------------------------------------
module dcd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  dcd_pkg::dcd_req_t q_data,
    input  logic              q_valid,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata
);
    import dcd_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_START = 11'b00000000100,
        S_SHEAD = 11'b00000001000,
        S_PUSH  = 11'b00000010000,
        S_TOP   = 11'b00000100000,
        S_CUR   = 11'b00001000000,
        S_EDGE  = 11'b00010000000,
        S_CHILD = 11'b00100000000,
        S_PHEAD = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t            st_reg, st_next;
    logic [CNT_W-1:0]  edges_reg;
    logic              drop_reg, found_reg;
    logic [FIELD_W-1:0] nodes_reg;
    logic [FIELD_W-1:0] src_reg;
    logic [SP_W-1:0]   sp_reg;
    logic [NODE_W-1:0] clr_reg;
    logic [NODE_W-1:0] child_reg;

    // Memory ports.
    logic              hd_we, vi_we, op_we, sn_we, sc_we, ln_we, et_we;
    logic [NODE_W-1:0] hd_wa, hd_ra, vi_wa, vi_ra, op_wa, op_ra, sn_wa, sn_ra, sc_wa, sc_ra;
    logic [EDGE_W:0]   hd_wd, hd_rd, ln_wd, ln_rd, sc_wd, sc_rd;
    logic [EDGE_W-1:0] ln_wa, ln_ra, et_wa, et_ra;
    logic              vi_wd, vi_rd, op_wd, op_rd;
    logic [NODE_W-1:0] sn_wd, sn_rd, et_wd, et_rd;
    logic [NODE_W-1:0] sp_top;

    localparam logic [EDGE_W:0] EMPTY = (EDGE_W+1)'(MAX_EDGES);

    assign sp_top = NODE_W'(sp_reg - 1'b1);

    dcd_ram #(.WIDTH(EDGE_W+1), .DEPTH(MAX_NODES)) u_head (.aclk, .we(hd_we), .waddr(hd_wa),
        .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
    dcd_ram #(.WIDTH(EDGE_W+1), .DEPTH(MAX_EDGES)) u_next (.aclk, .we(ln_we), .waddr(ln_wa),
        .wdata(ln_wd), .raddr(ln_ra), .rdata(ln_rd));
    dcd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_tgt (.aclk, .we(et_we), .waddr(et_wa),
        .wdata(et_wd), .raddr(et_ra), .rdata(et_rd));
    dcd_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_vis (.aclk, .we(vi_we), .waddr(vi_wa),
        .wdata(vi_wd), .raddr(vi_ra), .rdata(vi_rd));
    dcd_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_onp (.aclk, .we(op_we), .waddr(op_wa),
        .wdata(op_wd), .raddr(op_ra), .rdata(op_rd));
    dcd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_snode (.aclk, .we(sn_we), .waddr(sn_wa),
        .wdata(sn_wd), .raddr(sn_ra), .rdata(sn_rd));
    dcd_ram #(.WIDTH(EDGE_W+1), .DEPTH(MAX_NODES)) u_scur (.aclk, .we(sc_we), .waddr(sc_wa),
        .wdata(sc_wd), .raddr(sc_ra), .rdata(sc_rd));

    assign m_tvalid = (st_reg == S_OUT);
    assign m_tdata  = {6'd0, drop_reg, found_reg};

    // Sequencer and memory port control.
    always_comb begin
        st_next = st_reg;
        q_pop = 1'b0;
        hd_we = 1'b0; hd_wa = q_data.from_idx; hd_wd = (EDGE_W+1)'(edges_reg);
        hd_ra = q_data.from_idx;
        ln_we = 1'b0; ln_wa = EDGE_W'(edges_reg); ln_wd = hd_rd; ln_ra = EDGE_W'(sc_rd);
        et_we = 1'b0; et_wa = EDGE_W'(edges_reg); et_wd = q_data.to_idx;
        et_ra = EDGE_W'(sc_rd);
        vi_we = 1'b0; vi_wa = NODE_W'(src_reg); vi_wd = 1'b1; vi_ra = NODE_W'(src_reg);
        op_we = 1'b0; op_wa = NODE_W'(src_reg); op_wd = 1'b1; op_ra = child_reg;
        sn_we = 1'b0; sn_wa = NODE_W'(sp_reg); sn_wd = child_reg; sn_ra = sp_top;
        sc_we = 1'b0; sc_wa = NODE_W'(sp_reg); sc_wd = hd_rd; sc_ra = sp_top;
        unique case (st_reg)
            S_CLEAR: begin
                hd_we = 1'b1; hd_wa = clr_reg; hd_wd = EMPTY;
                vi_we = 1'b1; vi_wa = clr_reg; vi_wd = 1'b0;
                op_we = 1'b1; op_wa = clr_reg; op_wd = 1'b0;
                if (clr_reg == NODE_W'(MAX_NODES - 1)) st_next = S_IDLE;
            end
            S_IDLE: begin
                // Head read of the source list was issued for this request.
                if (q_valid) st_next = S_START;
            end
            S_START: begin
                // Head data for q_data.from_idx is now valid.
                q_pop = 1'b1;
                if (q_data.store && edges_reg < CNT_W'(MAX_EDGES)) begin
                    hd_we = 1'b1;
                    ln_we = 1'b1;
                    et_we = 1'b1;
                end
                st_next = q_data.last ? S_SHEAD : S_IDLE;
            end
            S_SHEAD: begin
                // Choose next unvisited start node.
                hd_ra = NODE_W'(src_reg);
                if (src_reg >= nodes_reg) st_next = S_OUT;
                else st_next = S_PUSH;
            end
            S_PUSH: begin
                hd_ra = NODE_W'(src_reg);
                if (vi_rd) begin
                    st_next = S_SHEAD;
                end else begin
                    vi_we = 1'b1; op_we = 1'b1;
                    sn_we = 1'b1; sn_wa = '0; sn_wd = NODE_W'(src_reg);
                    sc_we = 1'b1; sc_wa = '0; sc_wd = hd_rd;
                    st_next = S_TOP;
                end
            end
            S_TOP: begin
                if (sp_reg == '0) st_next = S_SHEAD;
                else st_next = S_CUR;
            end
            S_CUR: begin
                // Stack top read data valid: sn_rd, sc_rd.
                if (sc_rd >= EMPTY) begin
                    op_we = 1'b1; op_wa = sn_rd; op_wd = 1'b0;
                    st_next = S_TOP;
                end else begin
                    ln_ra = EDGE_W'(sc_rd); et_ra = EDGE_W'(sc_rd);
                    st_next = S_EDGE;
                end
            end
            S_EDGE: begin
                sc_we = 1'b1; sc_wa = sp_top; sc_wd = ln_rd;
                op_ra = et_rd; vi_ra = et_rd; hd_ra = et_rd;
                st_next = S_CHILD;
            end
            S_CHILD: begin
                hd_ra = child_reg;
                if (op_rd) begin
                    st_next = S_OUT;
                end else if (!vi_rd && sp_reg < SP_W'(MAX_NODES)) begin
                    vi_we = 1'b1; vi_wa = child_reg;
                    op_we = 1'b1; op_wa = child_reg;
                    st_next = S_PHEAD;
                end else begin
                    st_next = S_TOP;
                end
            end
            S_PHEAD: begin
                sn_we = 1'b1; sc_we = 1'b1;
                st_next = S_TOP;
            end
            S_OUT: begin
                if (m_tready) st_next = S_CLEAR;
            end
            default: st_next = S_CLEAR;
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= S_CLEAR;
            clr_reg   <= '0;
            edges_reg <= '0;
            drop_reg  <= 1'b0;
            found_reg <= 1'b0;
            sp_reg    <= '0;
            src_reg   <= '0;
        end else begin
            st_reg <= st_next;
            unique case (st_reg)
                S_CLEAR: begin
                    clr_reg   <= clr_reg + 1'b1;
                    edges_reg <= '0;
                    drop_reg  <= 1'b0;
                    found_reg <= 1'b0;
                    src_reg   <= '0;
                    sp_reg    <= '0;
                end
                S_START: begin
                    if (q_data.store && edges_reg < CNT_W'(MAX_EDGES)) begin
                        edges_reg <= edges_reg + 1'b1;
                    end else begin
                        drop_reg <= 1'b1;
                    end
                    nodes_reg <= q_data.nodes;
                    src_reg   <= '0;
                end
                S_PUSH: begin
                    if (!vi_rd) sp_reg <= SP_W'(1);
                    src_reg <= src_reg + 1'b1;
                end
                S_SHEAD: ;
                S_TOP: ;
                S_CUR: begin
                    if (sc_rd >= EMPTY) sp_reg <= sp_reg - 1'b1;
                end
                S_EDGE: child_reg <= et_rd;
                S_CHILD: begin
                    if (op_rd) found_reg <= 1'b1;
                end
                S_PHEAD: sp_reg <= sp_reg + 1'b1;
                S_IDLE: ;
                S_OUT: clr_reg <= '0;
                default: ;
            endcase
        end
    end

endmodule

// ----- hdl/directed_cycle_detector_top.sv -----
// ----------------------------------------------------------------------------
// Directed cycle detector
// Checks a stream of directed edges for a cycle by depth-first search.
// ----------------------------------------------------------------------------
// Edge requests enter a four-entry queue at one per cycle while it has room,
// and the back end stores each edge in S_IDLE (a head read), then S_START (the
// list writes), so a long burst settles at the back end's pace. After the last
// edge the walk passes S_SHEAD and S_PUSH for each start node it checks, S_TOP,
// S_CUR, S_EDGE and S_CHILD for each stored edge it follows plus S_PHEAD when
// that edge leads to a new node, and S_TOP and S_CUR when a node's list runs
// out; all of this is set by the registered reads of the list and mark memories.
// The result is offered in S_OUT. After each result and after reset a clearing
// pass over all 1024 nodes runs, during which only the queue takes edges.
module directed_cycle_detector_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        node_count_we,
    input  logic [10:0] node_count_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // from_node[10:0], to_node[21:11], zero pad
    input  logic        s_tlast,   // last_edge
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // cycle_found[0], edge_error[1], zero pad
);
    import dcd_pkg::*;

    logic [10:0] node_count_reg;
    dcd_req_t    q_data;
    logic        q_valid, q_pop;

    // Node count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= 11'd1024;
        end else if (node_count_we) begin
            node_count_reg <= node_count_wdata;
        end
    end

    dcd_front u_front (.aclk, .aresetn, .node_count(node_count_reg), .s_tvalid, .s_tready,
        .s_tdata(s_tdata[21:0]), .s_tlast, .q_data, .q_valid, .q_pop);

    dcd_back u_back (.aclk, .aresetn, .q_data, .q_valid, .q_pop, .m_tvalid, .m_tready,
        .m_tdata);

endmodule

// ----- hdl/dcd_checker.sv -----
// ----------------------------------------------------------------------------
// Detector port checker
// Watches the top level ports for result handshake slips.
// ----------------------------------------------------------------------------
module dcd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A result holds until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // No back-to-back results: the clearing pass follows each.
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("result repeated");

    // Pad bits are zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:2] == 6'd0)
        else $error("nonzero pad bits");

    // No result right after reset.
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result after reset");

endmodule

bind directed_cycle_detector_top dcd_checker u_dcd_checker (.aclk, .aresetn, .m_tvalid,
    .m_tready, .m_tdata);
